// ----- design/pit_pkg.sv -----
// Shared widths, register indexes and payload types of the cylinder test
package pit_pkg;

  // Coordinate and arithmetic widths
  localparam int COORD_W    = 24;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int PP_W       = 2 * COORD_W + 1;
  localparam int DOT_W      = PROD_W + 2;
  localparam int PSQ_W      = PP_W + 2;
  localparam int SQ_W       = 52;
  localparam int QUO_W      = 50;
  localparam int HALF_W     = QUO_W / 2;
  localparam int NUM_W      = 2 * QUO_W;
  localparam int REM_W      = SQ_W;
  localparam int DIV_STEPS  = QUO_W;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = SQ_W;

  localparam logic [CFG_IDX_W-1:0] REG_AXIS_START_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_START_Y = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_START_Z = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_END_X   = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_END_Y   = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_END_Z   = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_LEN_SQ  = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ    = 8'd7;

  // Side data that travels with a division
  typedef struct packed {
    logic             cap_ok;
    logic [PSQ_W-1:0] psq;
  } div_tag_t;

  // One step of the restoring divider
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] num;
    logic [QUO_W-1:0] quo;
    div_tag_t         tag;
  } div_stage_t;

endpackage

// ----- design/pit_if.sv -----
// Channel interfaces: test point, result and configuration write
interface pit_point_if;
  logic                                valid;
  logic                                ready;
  logic signed [pit_pkg::COORD_W-1:0]  point_x;
  logic signed [pit_pkg::COORD_W-1:0]  point_y;
  logic signed [pit_pkg::COORD_W-1:0]  point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

interface pit_result_if;
  logic                       valid;
  logic                       ready;
  logic                       inside_res;
  logic [pit_pkg::SQ_W-1:0]   axis_dist_sq;

  modport source (output valid, output inside_res, output axis_dist_sq, input ready);
  modport sink   (input valid, input inside_res, input axis_dist_sq, output ready);
endinterface

interface pit_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pit_pkg::CFG_IDX_W-1:0]    idx;
  logic [pit_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

// ----- design/pit_div.sv -----
// Pipelined restoring divider, one quotient bit per stage
module pit_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pit_pkg::SQ_W-1:0]    divisor_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  pit_pkg::div_stage_t         in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pit_pkg::div_stage_t         out_data_o
);

  pit_pkg::div_stage_t             st_q  [pit_pkg::DIV_STEPS];
  logic [pit_pkg::DIV_STEPS-1:0]   vld_q;
  logic [pit_pkg::DIV_STEPS:0]     rdy;

  // Ready ripples back: a stage takes a beat when empty or when it moves on
  assign rdy[pit_pkg::DIV_STEPS] = out_ready_i;
  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[pit_pkg::DIV_STEPS-1];
  assign out_data_o  = st_q[pit_pkg::DIV_STEPS-1];

  for (genvar k = 0; k < pit_pkg::DIV_STEPS; k++) begin : g_step
    pit_pkg::div_stage_t          prev;
    pit_pkg::div_stage_t          st_d;
    logic                         prev_vld;
    logic [pit_pkg::REM_W:0]      trial;
    logic [pit_pkg::REM_W+1:0]    diff;
    logic                         take;

    if (k == 0) begin : g_head
      assign prev     = in_data_i;
      assign prev_vld = in_valid_i;
    end else begin : g_body
      assign prev     = st_q[k-1];
      assign prev_vld = vld_q[k-1];
    end

    assign rdy[k] = !vld_q[k] || rdy[k+1];

    // Shift in the next dividend bit, subtract the divisor where it fits
    always_comb begin
      trial = {prev.rem, prev.num[pit_pkg::QUO_W-1]};
      diff  = {1'b0, trial} - {2'b00, divisor_i};
      take  = !diff[pit_pkg::REM_W+1];
      st_d.rem = take ? diff[pit_pkg::REM_W-1:0] : trial[pit_pkg::REM_W-1:0];
      st_d.num = {prev.num[pit_pkg::QUO_W-2:0], 1'b0};
      st_d.quo = {prev.quo[pit_pkg::QUO_W-2:0], take};
      st_d.tag = prev.tag;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= prev_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && prev_vld) begin
        st_q[k] <= st_d;
      end
    end
  end

endmodule

// ----- design/point_in_cylinder_test.sv -----
// Capped cylinder membership test: a pipeline of multiply, sum, square and divide.
// Each accepted point beat passes stages 1 to 5, the divider and stages 6 and 7 to res_o.
// Throughput: one point per cycle while res_o is ready; the 50-stage divider (one quotient bit per
// stage) sets the depth, and any stage moves on whenever the one after it frees.
// Reset: rst_ni clears all valid bits and the configuration registers to zero.
module point_in_cylinder_test (
  input  logic            clk_i,
  input  logic            rst_ni,
  pit_cfg_if.sink         cfg_i,
  pit_point_if.sink       pt_i,
  pit_result_if.source    res_o
);

  typedef struct packed {
    logic signed [pit_pkg::COORD_W-1:0] start_x;
    logic signed [pit_pkg::COORD_W-1:0] start_y;
    logic signed [pit_pkg::COORD_W-1:0] start_z;
    logic signed [pit_pkg::COORD_W-1:0] end_x;
    logic signed [pit_pkg::COORD_W-1:0] end_y;
    logic signed [pit_pkg::COORD_W-1:0] end_z;
    logic [pit_pkg::SQ_W-1:0]           len_sq;
    logic [pit_pkg::SQ_W-1:0]           rad_sq;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [pit_pkg::DIFF_W-1:0] x;
    logic signed [pit_pkg::DIFF_W-1:0] y;
    logic signed [pit_pkg::DIFF_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [pit_pkg::PROD_W-1:0] pd_x;
    logic signed [pit_pkg::PROD_W-1:0] pd_y;
    logic signed [pit_pkg::PROD_W-1:0] pd_z;
    logic [pit_pkg::PP_W-1:0]          pp_x;
    logic [pit_pkg::PP_W-1:0]          pp_y;
    logic [pit_pkg::PP_W-1:0]          pp_z;
  } prod_t;

  typedef struct packed {
    logic signed [pit_pkg::DOT_W-1:0] dot;
    logic [pit_pkg::PSQ_W-1:0]        psq;
  } sums_t;

  typedef struct packed {
    logic                         cap_ok;
    logic [pit_pkg::PSQ_W-1:0]    psq;
    logic [2*pit_pkg::HALF_W-1:0] hh;
    logic [2*pit_pkg::HALF_W-1:0] hl;
    logic [2*pit_pkg::HALF_W-1:0] ll;
  } sqpart_t;

  typedef struct packed {
    logic                         cap_ok;
    logic [pit_pkg::PSQ_W-1:0]    dsq;
  } dist_t;

  typedef struct packed {
    logic                         in_cyl;
    logic [pit_pkg::SQ_W-1:0]     dist_sq;
  } result_t;

  cfg_regs_t            cfg_q;
  vec_t                 dir_q, dir_d;
  vec_t                 s1_q, s1_d;
  prod_t                s2_q, s2_d;
  sums_t                s3_q, s3_d;
  sqpart_t              s4_q, s4_d;
  pit_pkg::div_stage_t  s5_q, s5_d;
  dist_t                s6_q, s6_d;
  result_t              s7_q, s7_d;
  logic                 s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, s7_v_q;
  logic                 s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, s6_rdy, s7_rdy;
  logic                 div_in_rdy, div_out_vld;
  pit_pkg::div_stage_t  div_out;

  logic signed [pit_pkg::PROD_W-1:0]  sq_x, sq_y, sq_z;
  logic [pit_pkg::HALF_W-1:0]         dot_hi, dot_lo;
  logic [pit_pkg::NUM_W-1:0]          dot_sq;
  logic [pit_pkg::QUO_W-1:0]          quo_eff;

  // Register writes; the port never stalls
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.idx)
        pit_pkg::REG_AXIS_START_X: cfg_q.start_x <= cfg_i.data[pit_pkg::COORD_W-1:0];
        pit_pkg::REG_AXIS_START_Y: cfg_q.start_y <= cfg_i.data[pit_pkg::COORD_W-1:0];
        pit_pkg::REG_AXIS_START_Z: cfg_q.start_z <= cfg_i.data[pit_pkg::COORD_W-1:0];
        pit_pkg::REG_AXIS_END_X:   cfg_q.end_x   <= cfg_i.data[pit_pkg::COORD_W-1:0];
        pit_pkg::REG_AXIS_END_Y:   cfg_q.end_y   <= cfg_i.data[pit_pkg::COORD_W-1:0];
        pit_pkg::REG_AXIS_END_Z:   cfg_q.end_z   <= cfg_i.data[pit_pkg::COORD_W-1:0];
        pit_pkg::REG_AXIS_LEN_SQ:  cfg_q.len_sq  <= cfg_i.data;
        pit_pkg::REG_RADIUS_SQ:    cfg_q.rad_sq  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Hold the axis direction, refreshed from the registers every cycle
  always_comb begin
    dir_d.x = pit_pkg::DIFF_W'(cfg_q.end_x) - pit_pkg::DIFF_W'(cfg_q.start_x);
    dir_d.y = pit_pkg::DIFF_W'(cfg_q.end_y) - pit_pkg::DIFF_W'(cfg_q.start_y);
    dir_d.z = pit_pkg::DIFF_W'(cfg_q.end_z) - pit_pkg::DIFF_W'(cfg_q.start_z);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= '0;
    end else begin
      dir_q <= dir_d;
    end
  end

  // Ready chain back from the result port
  assign s7_rdy     = !s7_v_q || res_o.ready;
  assign s6_rdy     = !s6_v_q || s7_rdy;
  assign s5_rdy     = !s5_v_q || div_in_rdy;
  assign s4_rdy     = !s4_v_q || s5_rdy;
  assign s3_rdy     = !s3_v_q || s4_rdy;
  assign s2_rdy     = !s2_v_q || s3_rdy;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign pt_i.ready = s1_rdy;

  // Stage 1: point relative to the axis start
  always_comb begin
    s1_d.x = pit_pkg::DIFF_W'(pt_i.point_x) - pit_pkg::DIFF_W'(cfg_q.start_x);
    s1_d.y = pit_pkg::DIFF_W'(pt_i.point_y) - pit_pkg::DIFF_W'(cfg_q.start_y);
    s1_d.z = pit_pkg::DIFF_W'(pt_i.point_z) - pit_pkg::DIFF_W'(cfg_q.start_z);
  end

  // Stage 2: projection terms and squared offsets
  always_comb begin
    sq_x      = s1_q.x * s1_q.x;
    sq_y      = s1_q.y * s1_q.y;
    sq_z      = s1_q.z * s1_q.z;
    s2_d.pd_x = s1_q.x * dir_q.x;
    s2_d.pd_y = s1_q.y * dir_q.y;
    s2_d.pd_z = s1_q.z * dir_q.z;
    s2_d.pp_x = sq_x[pit_pkg::PP_W-1:0];
    s2_d.pp_y = sq_y[pit_pkg::PP_W-1:0];
    s2_d.pp_z = sq_z[pit_pkg::PP_W-1:0];
  end

  // Stage 3: dot product and squared length of the offset
  always_comb begin
    s3_d.dot = pit_pkg::DOT_W'(s2_q.pd_x) + pit_pkg::DOT_W'(s2_q.pd_y)
             + pit_pkg::DOT_W'(s2_q.pd_z);
    s3_d.psq = pit_pkg::PSQ_W'(s2_q.pp_x) + pit_pkg::PSQ_W'(s2_q.pp_y)
             + pit_pkg::PSQ_W'(s2_q.pp_z);
  end

  // Stage 4: cap test, and the dot square split into half-width products
  always_comb begin
    dot_hi      = s3_q.dot[pit_pkg::QUO_W-1:pit_pkg::HALF_W];
    dot_lo      = s3_q.dot[pit_pkg::HALF_W-1:0];
    s4_d.cap_ok = !s3_q.dot[pit_pkg::DOT_W-1]
               && (pit_pkg::SQ_W'(s3_q.dot[pit_pkg::DOT_W-2:0]) <= cfg_q.len_sq);
    s4_d.psq    = s3_q.psq;
    s4_d.hh     = dot_hi * dot_hi;
    s4_d.hl     = dot_hi * dot_lo;
    s4_d.ll     = dot_lo * dot_lo;
  end

  // Stage 5: assemble the dividend; its top half is the first remainder
  always_comb begin
    dot_sq = {s4_q.hh, {(2*pit_pkg::HALF_W){1'b0}}}
           + {{(pit_pkg::NUM_W-2*pit_pkg::HALF_W-pit_pkg::HALF_W-1){1'b0}}, s4_q.hl,
              {(pit_pkg::HALF_W+1){1'b0}}}
           + pit_pkg::NUM_W'(s4_q.ll);
    s5_d.rem        = pit_pkg::REM_W'(dot_sq[pit_pkg::NUM_W-1:pit_pkg::QUO_W]);
    s5_d.num        = dot_sq[pit_pkg::QUO_W-1:0];
    s5_d.quo        = '0;
    s5_d.tag.cap_ok = s4_q.cap_ok;
    s5_d.tag.psq    = s4_q.psq;
  end

  pit_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .divisor_i   (cfg_q.len_sq),
    .in_valid_i  (s5_v_q),
    .in_ready_o  (div_in_rdy),
    .in_data_i   (s5_q),
    .out_valid_o (div_out_vld),
    .out_ready_i (s6_rdy),
    .out_data_o  (div_out)
  );

  // Stage 6: distance to the axis, clamped at zero; zero length gives no quotient
  always_comb begin
    quo_eff     = (cfg_q.len_sq == '0) ? '0 : div_out.quo;
    s6_d.cap_ok = div_out.tag.cap_ok;
    s6_d.dsq    = (div_out.tag.psq >= pit_pkg::PSQ_W'(quo_eff))
                ? div_out.tag.psq - pit_pkg::PSQ_W'(quo_eff) : '0;
  end

  // Stage 7: radius test into the output register
  always_comb begin
    s7_d.in_cyl  = s6_q.cap_ok && (pit_pkg::SQ_W'(s6_q.dsq) <= cfg_q.rad_sq);
    s7_d.dist_sq = s7_d.in_cyl ? pit_pkg::SQ_W'(s6_q.dsq) : '0;
  end

  // Valid bits advance with their stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= pt_i.valid;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (s3_rdy) s3_v_q <= s2_v_q;
      if (s4_rdy) s4_v_q <= s3_v_q;
      if (s5_rdy) s5_v_q <= s4_v_q;
      if (s6_rdy) s6_v_q <= div_out_vld;
      if (s7_rdy) s7_v_q <= s6_v_q;
    end
  end

  // Payload registers load only with a valid beat
  always_ff @(posedge clk_i) begin
    if (s1_rdy && pt_i.valid) s1_q <= s1_d;
    if (s2_rdy && s1_v_q)     s2_q <= s2_d;
    if (s3_rdy && s2_v_q)     s3_q <= s3_d;
    if (s4_rdy && s3_v_q)     s4_q <= s4_d;
    if (s5_rdy && s4_v_q)     s5_q <= s5_d;
    if (s6_rdy && div_out_vld) s6_q <= s6_d;
    if (s7_rdy && s6_v_q)     s7_q <= s7_d;
  end

  assign res_o.valid        = s7_v_q;
  assign res_o.inside_res   = s7_q.in_cyl;
  assign res_o.axis_dist_sq = s7_q.dist_sq;

endmodule

// ----- design/pit_checker.sv -----
// Port-level checks of the cylinder test, bound to the top level
module pit_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          inside_i,
  input  logic [pit_pkg::SQ_W-1:0]      dist_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [pit_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pit_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CNT_W = 8;

  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [pit_pkg::SQ_W-1:0]  rad_q;
  logic                      in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign cnt_d   = cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);

  // Track beats in flight and the radius written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rad_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_valid_i && cfg_ready_i && (cfg_idx_i == pit_pkg::REG_RADIUS_SQ)) begin
        rad_q <= cfg_data_i;
      end
    end
  end

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(inside_i) && $stable(dist_i))
    else $error("result beat changed while stalled");

  // No result without a point in flight
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result beat with no point outstanding");

  // An inside point lies within the radius
  a_in_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && inside_i |-> dist_i <= rad_q)
    else $error("inside result beyond the radius");

  // An outside point reports zero distance
  a_out_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !inside_i |-> dist_i == '0)
    else $error("outside result with nonzero distance");

endmodule

bind point_in_cylinder_test pit_checker u_pit_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pt_i.valid),
  .in_ready_i  (pt_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .inside_i    (res_o.inside_res),
  .dist_i      (res_o.axis_dist_sq),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .cfg_idx_i   (cfg_i.idx),
  .cfg_data_i  (cfg_i.data)
);
